/* rtl/pffl_pkg.sv */
// ----------------------------------------------------------------------------
// pffl_pkg
// Shared types and codes for the page frame free-list allocator.
// ----------------------------------------------------------------------------
package pffl_pkg;

   localparam int CFG_W      = 13;
   localparam int MODE_W     = 2;
   localparam int PAGES_W    = 8;
   localparam int FRAME_W    = 12;
   localparam int STATUS_W   = 4;
   localparam int REFS_W     = 8;
   localparam int CSR_IDX_W  = 1;

   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_INIT  = 2'd0;
   localparam mode_type MODE_ALLOC = 2'd1;
   localparam mode_type MODE_FREE  = 2'd2;
   localparam mode_type MODE_NONE  = 2'd3;

   localparam status_type ST_INIT     = 4'd0;
   localparam status_type ST_ALLOC    = 4'd1;
   localparam status_type ST_FREED    = 4'd2;
   localparam status_type ST_LOWERED  = 4'd3;
   localparam status_type ST_EMPTY    = 4'd4;
   localparam status_type ST_MULTI    = 4'd5;
   localparam status_type ST_DOUBLE   = 4'd6;
   localparam status_type ST_NOTREADY = 4'd7;
   localparam status_type ST_BADINDEX = 4'd8;

   localparam csr_idx_type CSR_TOTAL    = 1'd0;
   localparam csr_idx_type CSR_RESERVED = 1'd1;

   // controller -> datapath
   typedef struct packed {
      logic       init_start;
      logic       init_step;
      logic       init_done;
      logic       op_load;
      logic       load_alloc;
      logic       op_exec;
      logic       quick;
      status_type quick_code;
   } pffl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ready;
      logic empty;
      logic multi;
      logic idx_bad;
      logic init_last;
   } pffl_sts_type;

endpackage

/* rtl/pffl_ctrl.sv */
// ----------------------------------------------------------------------------
// pffl_ctrl
// Sequencer: classifies requests, runs the table build and the
// read-then-write cycle of alloc and free.
// ----------------------------------------------------------------------------
module pffl_ctrl
   import pffl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  mode_type     req_mode,
   input  pffl_sts_type sts,
   output pffl_cmd_type cmd,
   output logic         busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_INIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.quick_code = ST_INIT;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_INIT: begin
                     cmd.init_start = 1'b1;
                     state_in       = S_INIT;
                  end
                  MODE_NONE: begin
                     cmd.quick      = 1'b1;
                     cmd.quick_code = ST_BADINDEX;
                  end
                  MODE_ALLOC: begin
                     priority if (!sts.ready) begin
                        cmd.quick      = 1'b1;
                        cmd.quick_code = ST_NOTREADY;
                     end else if (sts.multi) begin
                        cmd.quick      = 1'b1;
                        cmd.quick_code = ST_MULTI;
                     end else if (sts.empty) begin
                        cmd.quick      = 1'b1;
                        cmd.quick_code = ST_EMPTY;
                     end else begin
                        cmd.op_load    = 1'b1;
                        cmd.load_alloc = 1'b1;
                        state_in       = S_EXEC;
                     end
                  end
                  default: begin
                     priority if (!sts.ready) begin
                        cmd.quick      = 1'b1;
                        cmd.quick_code = ST_NOTREADY;
                     end else if (sts.idx_bad) begin
                        cmd.quick      = 1'b1;
                        cmd.quick_code = ST_BADINDEX;
                     end else begin
                        cmd.op_load = 1'b1;
                        state_in    = S_EXEC;
                     end
                  end
               endcase
            end
         end
         S_EXEC: begin
            cmd.op_exec = 1'b1;
            state_in    = S_IDLE;
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               cmd.init_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // table access always completes in the following cycle
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.op_load |=> cmd.op_exec)
      else $error("op_load not followed by op_exec");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_start, cmd.init_step, cmd.op_load, cmd.op_exec, cmd.quick}))
      else $error("overlapping datapath commands");

   a_done_in_init: assert property (@(posedge clock) disable iff (reset)
      cmd.init_done |-> cmd.init_step && busy)
      else $error("init_done outside table build");

endmodule

/* rtl/pffl_dpath.sv */
// ----------------------------------------------------------------------------
// pffl_dpath
// Frame table (link and refcount memories), list head, config registers
// and the result register.
// ----------------------------------------------------------------------------
module pffl_dpath
   import pffl_pkg::*;
#(
   parameter int MAX_FRAMES = 4096
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  pffl_cmd_type         cmd,
   output pffl_sts_type         sts,
   input  logic                 csr_we,
   input  csr_idx_type          csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [PAGES_W-1:0]   req_page_count,
   input  logic [FRAME_W-1:0]   req_frame_index,
   output logic                 rsp_valid,
   output status_type           rsp_status,
   output logic [FRAME_W-1:0]   rsp_granted_frame,
   output logic [REFS_W-1:0]    rsp_remaining_refs
);

   localparam int IDX_W  = $clog2(MAX_FRAMES);
   localparam int LINK_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W  = (LINK_W > CFG_W) ? LINK_W : CFG_W;
   localparam logic [LINK_W-1:0] NIL      = LINK_W'(MAX_FRAMES);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_FRAMES - 1);

   logic [REFS_W-1:0] ref_mem  [MAX_FRAMES];
   logic [LINK_W-1:0] link_mem [MAX_FRAMES];

   logic [CFG_W-1:0]  total_ff, total_in;
   logic [CFG_W-1:0]  resv_ff, resv_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] live_ff, live_in;
   logic              ready_ff, ready_in;
   logic [LINK_W-1:0] n_ff, n_in;
   logic [LINK_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              alloc_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [REFS_W-1:0] rd_ref_ff;
   logic [LINK_W-1:0] rd_link_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [REFS_W-1:0] rsp_refs_ff, rsp_refs_in;

   logic              we;
   logic [IDX_W-1:0]  waddr;
   logic [REFS_W-1:0] wref;
   logic [LINK_W-1:0] wlink;
   logic [IDX_W-1:0]  raddr;
   logic [CMP_W-1:0]  n_clip;
   logic [CMP_W-1:0]  r_clip;
   logic [LINK_W-1:0] cnt_ext;
   logic [REFS_W-1:0] ref_dec;

   assign sts.ready     = ready_ff;
   assign sts.empty     = (head_ff == NIL);
   assign sts.multi     = (req_page_count > PAGES_W'(1));
   assign sts.idx_bad   = (CMP_W'(req_frame_index) >= CMP_W'(live_ff));
   assign sts.init_last = (cnt_ff == LAST_IDX);

   assign n_clip  = (CMP_W'(total_ff) > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES)
                                                             : CMP_W'(total_ff);
   assign r_clip  = (CMP_W'(resv_ff) > n_clip) ? n_clip : CMP_W'(resv_ff);
   assign cnt_ext = LINK_W'(cnt_ff);
   assign ref_dec = rd_ref_ff - REFS_W'(1);
   assign raddr   = cmd.load_alloc ? head_ff[IDX_W-1:0] : IDX_W'(req_frame_index);

   always_comb begin
      total_in = total_ff;
      resv_in  = resv_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL:    total_in = csr_wdata;
            CSR_RESERVED: resv_in  = csr_wdata;
            default:      total_in = total_ff;
         endcase
      end
   end

   always_comb begin
      head_in        = head_ff;
      live_in        = live_ff;
      ready_in       = ready_ff;
      n_in           = n_ff;
      r_in           = r_ff;
      cnt_in         = cnt_ff;
      we             = 1'b0;
      waddr          = addr_ff;
      wref           = '0;
      wlink          = NIL;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = '0;
      rsp_refs_in    = '0;

      if (cmd.init_start) begin
         n_in   = LINK_W'(n_clip);
         r_in   = LINK_W'(r_clip);
         cnt_in = '0;
      end

      if (cmd.init_step) begin
         we     = 1'b1;
         waddr  = cnt_ff;
         cnt_in = cnt_ff + IDX_W'(1);
         if (cnt_ext < r_ff) begin
            wref  = REFS_W'(1);
            wlink = NIL;
         end else begin
            wref  = '0;
            wlink = ((cnt_ext + LINK_W'(1)) < n_ff) ? cnt_ext + LINK_W'(1) : NIL;
         end
      end

      if (cmd.init_done) begin
         live_in       = n_ff;
         head_in       = (r_ff < n_ff) ? r_ff : NIL;
         ready_in      = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_INIT;
      end

      if (cmd.quick) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.quick_code;
      end

      if (cmd.op_exec) begin
         rsp_valid_in = 1'b1;
         if (alloc_ff) begin
            we             = 1'b1;
            wref           = REFS_W'(1);
            wlink          = NIL;
            head_in        = rd_link_ff;
            rsp_status_in  = ST_ALLOC;
            rsp_granted_in = FRAME_W'(addr_ff);
         end else begin
            priority if (rd_ref_ff == REFS_W'(1)) begin
               we            = 1'b1;
               wref          = '0;
               wlink         = head_ff;
               head_in       = LINK_W'(addr_ff);
               rsp_status_in = ST_FREED;
            end else if (rd_ref_ff == '0) begin
               rsp_status_in = ST_DOUBLE;
            end else begin
               we            = 1'b1;
               wref          = ref_dec;
               wlink         = rd_link_ff;
               rsp_status_in = ST_LOWERED;
               rsp_refs_in   = ref_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= CFG_W'(4096);
         resv_ff      <= '0;
         head_ff      <= NIL;
         live_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         resv_ff      <= resv_in;
         head_ff      <= head_in;
         live_ff      <= live_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      r_ff           <= r_in;
      cnt_ff         <= cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_refs_ff    <= rsp_refs_in;
      if (cmd.op_load) begin
         alloc_ff <= cmd.load_alloc;
         addr_ff  <= raddr;
      end
   end

   // frame table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         ref_mem[waddr]  <= wref;
         link_mem[waddr] <= wlink;
      end
      if (cmd.op_load) begin
         rd_ref_ff  <= ref_mem[raddr];
         rd_link_ff <= link_mem[raddr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_frame  = rsp_granted_ff;
   assign rsp_remaining_refs = rsp_refs_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.quick || cmd.op_exec || cmd.init_done))
      else $error("result strobe without a finishing command");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NIL)
      else $error("free list head out of range");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(ready_ff) |-> ready_ff)
      else $error("table ready dropped without reset");

endmodule

/* rtl/page_frame_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator
// Page frame allocator over a linked free list with per-frame refcounts.
// ----------------------------------------------------------------------------
// Alloc/free: busy for one cycle after start, rsp_valid in the cycle after busy; a new
//   request is taken only when busy is low, after the read then write of one table entry.
// Refused requests: rsp_valid in the cycle after start, busy stays low.
// Init: busy while the table is built, one table entry written per cycle, then rsp_valid.
// Reset: config back to defaults, table not ready; entries undefined until init.
// The result is strobed for exactly one cycle; the receiver cannot stall.
module page_frame_free_list_allocator
   import pffl_pkg::*;
#(
   parameter int MAX_FRAMES = 4096
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mode_type             req_mode,
   input  logic [PAGES_W-1:0]   req_page_count,
   input  logic [FRAME_W-1:0]   req_frame_index,
   output logic                 rsp_valid,
   output status_type           rsp_status,
   output logic [FRAME_W-1:0]   rsp_granted_frame,
   output logic [REFS_W-1:0]    rsp_remaining_refs,
   input  logic                 csr_we,
   input  csr_idx_type          csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   pffl_cmd_type cmd;
   pffl_sts_type sts;

   pffl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   pffl_dpath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_page_count     (req_page_count),
      .req_frame_index    (req_frame_index),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_frame  (rsp_granted_frame),
      .rsp_remaining_refs (rsp_remaining_refs)
   );

endmodule
